// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent assertions of the address builder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define ATATF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset as well.
`define ATATF_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/atatf_pkg.sv =====
// ----------------------------------------------------------------------------
// atatf_pkg
// Types, constants and stage functions of the ATA task-file address builder.
// ----------------------------------------------------------------------------
package atatf_pkg;

    localparam int unsigned OFFSET_W   = 28;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned SPT_W      = 8;
    localparam int unsigned HEADS_W    = 5;
    localparam int unsigned PER_CYL_W  = SPT_W + HEADS_W;
    localparam int unsigned REM_W      = PER_CYL_W + 1;
    localparam int unsigned HEAD_Q_W   = 5;
    localparam int unsigned CYL_W      = 16;
    localparam int unsigned REG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [REG_IDX_W-1:0] REG_USE_LBA = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SPT     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HEADS   = 2'd2;

    localparam logic               RST_USE_LBA = 1'b1;
    localparam logic [SPT_W-1:0]   RST_SPT     = 8'd63;
    localparam logic [HEADS_W-1:0] RST_HEADS   = 5'd16;

    localparam logic [BYTE_W-1:0] DH_FIXED = 8'hA0;
    localparam logic [BYTE_W-1:0] DH_LBA   = 8'h40;
    localparam logic [CYL_W-1:0]  CYL_MAX  = 16'hFFFF;

    typedef enum logic [1:0] {
        KIND_NOT_READY,
        KIND_LBA,
        KIND_CHS
    } kind_t;

    // Command as classified by the front end.
    typedef struct packed {
        kind_t                kind;
        logic [OFFSET_W-1:0]  offset;
        logic [BYTE_W-1:0]    count;
        logic                 drive;
        logic [SPT_W-1:0]     spt;
        logic [HEADS_W-1:0]   heads;
    } item_t;

    // Working set carried down the divider pipeline.
    typedef struct packed {
        kind_t                kind;
        logic [BYTE_W-1:0]    count;
        logic                 drive;
        logic [SPT_W-1:0]     spt;
        logic [PER_CYL_W-1:0] per_cyl;
        logic [REM_W-1:0]     rem;
        logic [OFFSET_W-1:0]  quo;
        logic [HEAD_Q_W-1:0]  head;
    } work_t;

    typedef struct packed {
        logic              not_ready_error;
        logic [BYTE_W-1:0] count_byte;
        logic [BYTE_W-1:0] sector_or_lba_low;
        logic [BYTE_W-1:0] cyl_low_or_lba_mid;
        logic [BYTE_W-1:0] cyl_high_or_lba_high;
        logic [BYTE_W-1:0] drive_head_byte;
        logic              cylinder_overflow;
    } result_t;

    function automatic work_t load_work(input item_t i);
        work_t w;
        w.kind    = i.kind;
        w.count   = i.count;
        w.drive   = i.drive;
        w.spt     = i.spt;
        w.per_cyl = PER_CYL_W'(i.spt) * PER_CYL_W'(i.heads);
        w.rem     = '0;
        w.quo     = i.offset;
        w.head    = '0;
        return w;
    endfunction

    // One restoring step of offset / per_cyl. The quotient builds up in the
    // low bits of quo as the dividend shifts out of the top. Other kinds
    // hold still so that quo keeps the raw offset.
    function automatic work_t div_step(input work_t w);
        work_t            o;
        logic [REM_W-1:0] shifted;
        o = w;
        if (w.kind == KIND_CHS)
        begin
            shifted = {w.rem[REM_W-2:0], w.quo[OFFSET_W-1]};
            o.quo   = {w.quo[OFFSET_W-2:0], 1'b0};
            if (shifted >= {1'b0, w.per_cyl})
            begin
                o.rem    = shifted - {1'b0, w.per_cyl};
                o.quo[0] = 1'b1;
            end
            else
            begin
                o.rem = shifted;
            end
        end
        return o;
    endfunction

    // One head bit: the remainder is below spt * 32, so five compares
    // against spt shifted down from bit four give the head.
    function automatic work_t head_step(input work_t w, input int unsigned bit_pos);
        work_t            o;
        logic [REM_W-1:0] divisor;
        o       = w;
        divisor = REM_W'(w.spt) << bit_pos;
        if (w.rem >= divisor)
        begin
            o.rem  = w.rem - divisor;
            o.head = w.head | (HEAD_Q_W'(1) << bit_pos);
        end
        return o;
    endfunction

    function automatic result_t build_result(input work_t w);
        result_t           r;
        logic              ovf;
        logic [CYL_W-1:0]  cyl;
        r   = '0;
        ovf = |w.quo[OFFSET_W-1:CYL_W];
        cyl = ovf ? CYL_MAX : w.quo[CYL_W-1:0];
        case (w.kind)
            KIND_NOT_READY:
            begin
                r.not_ready_error = 1'b1;
            end
            KIND_LBA:
            begin
                r.count_byte           = w.count;
                r.sector_or_lba_low    = w.quo[7:0];
                r.cyl_low_or_lba_mid   = w.quo[15:8];
                r.cyl_high_or_lba_high = w.quo[23:16];
                r.drive_head_byte      = DH_FIXED | DH_LBA | {3'b000, w.drive, 4'b0000}
                                         | {4'b0000, w.quo[27:24]};
            end
            KIND_CHS:
            begin
                r.count_byte           = w.count;
                r.sector_or_lba_low    = w.rem[BYTE_W-1:0] + 8'd1;
                r.cyl_low_or_lba_mid   = cyl[7:0];
                r.cyl_high_or_lba_high = cyl[15:8];
                r.drive_head_byte      = DH_FIXED | {3'b000, w.drive, 4'b0000}
                                         | {4'b0000, w.head[3:0]};
                r.cylinder_overflow    = ovf;
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== design/atatf_queue.sv =====
// ----------------------------------------------------------------------------
// atatf_queue
// Small first-in first-out buffer with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module atatf_queue #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== design/atatf_front.sv =====
// ----------------------------------------------------------------------------
// atatf_front
// Holds the geometry registers and classifies each incoming command.
// ----------------------------------------------------------------------------
module atatf_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [atatf_pkg::REG_IDX_W-1:0]        wr_index,
    input  logic [atatf_pkg::CFG_DATA_W-1:0]       wr_data,
    input  logic [atatf_pkg::OFFSET_W-1:0]         sector_offset,
    input  logic [atatf_pkg::BYTE_W-1:0]           transfer_sectors,
    input  logic                                   drive_select,
    input  logic                                   drive_not_ready,
    output atatf_pkg::item_t                       item
);

    logic                              use_lba_reg;
    logic [atatf_pkg::SPT_W-1:0]       spt_reg;
    logic [atatf_pkg::HEADS_W-1:0]     heads_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_lba_reg <= atatf_pkg::RST_USE_LBA;
            spt_reg     <= atatf_pkg::RST_SPT;
            heads_reg   <= atatf_pkg::RST_HEADS;
        end
        else if (wr_en)
        begin
            case (wr_index)
                atatf_pkg::REG_USE_LBA: use_lba_reg <= wr_data[0];
                atatf_pkg::REG_SPT:     spt_reg     <= wr_data[atatf_pkg::SPT_W-1:0];
                atatf_pkg::REG_HEADS:   heads_reg   <= wr_data[atatf_pkg::HEADS_W-1:0];
                default:                ;
            endcase
        end
    end

    // A zero in either geometry register counts as one.
    always_comb
    begin
        if (drive_not_ready)
        begin
            item.kind = atatf_pkg::KIND_NOT_READY;
        end
        else if (use_lba_reg)
        begin
            item.kind = atatf_pkg::KIND_LBA;
        end
        else
        begin
            item.kind = atatf_pkg::KIND_CHS;
        end
        item.offset = sector_offset;
        item.count  = transfer_sectors;
        item.drive  = drive_select;
        item.spt    = (spt_reg == '0) ? atatf_pkg::SPT_W'(1) : spt_reg;
        item.heads  = (heads_reg == '0) ? atatf_pkg::HEADS_W'(1) : heads_reg;
    end

endmodule

// ===== design/atatf_back.sv =====
// ----------------------------------------------------------------------------
// atatf_back
// Divider pipeline: multiply, 28 quotient stages, 5 head stages, formatting.
// ----------------------------------------------------------------------------
module atatf_back (
    input  logic                clk,
    input  logic                rst_n,
    input  atatf_pkg::item_t    item,
    input  logic                item_valid,
    output logic                item_pop,
    output atatf_pkg::result_t  result,
    output logic                result_valid,
    input  logic                result_full
);

    localparam int unsigned DIV_LAST = atatf_pkg::OFFSET_W;
    localparam int unsigned STAGES   = 1 + atatf_pkg::OFFSET_W + atatf_pkg::HEAD_Q_W;

    logic [STAGES-1:0] valid_reg;
    atatf_pkg::work_t  stage_reg  [STAGES];
    atatf_pkg::work_t  stage_next [STAGES];
    logic              advance;

    // The whole pipeline moves together; it only halts when a finished
    // beat sits in the last stage and the result queue cannot take it.
    assign advance      = !valid_reg[STAGES-1] || !result_full;
    assign item_pop     = advance && item_valid;
    assign result_valid = valid_reg[STAGES-1];
    assign result       = atatf_pkg::build_result(stage_reg[STAGES-1]);

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        if (s == 0)
        begin : g_load
            assign stage_next[s] = atatf_pkg::load_work(item);
        end
        else if (s <= DIV_LAST)
        begin : g_div
            assign stage_next[s] = atatf_pkg::div_step(stage_reg[s-1]);
        end
        else
        begin : g_head
            assign stage_next[s] = atatf_pkg::head_step(stage_reg[s-1],
                atatf_pkg::HEAD_Q_W - 1 - (s - 1 - DIV_LAST));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], item_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

endmodule

// ===== design/ata_taskfile_address_builder_unit.sv =====
// ----------------------------------------------------------------------------
// ata_taskfile_address_builder_unit
// Builds ATA task-file bytes from a sector offset in LBA or CHS addressing.
//
//   Channel   Handshake          Payload
//   config    wr_en              wr_index, wr_data
//   command   push / full        sector_offset, transfer_sectors,
//                                drive_select, drive_not_ready
//   result    empty / pop        not_ready_error, count_byte, sector_or_lba_low,
//                                cyl_low_or_lba_mid, cyl_high_or_lba_high,
//                                drive_head_byte, cylinder_overflow
//
// One command per cycle is accepted while full is low, and one result per cycle is
// delivered while a result waits and pop is high. A pushed command passes the
// command queue, 34 pipeline stages (geometry multiply, 28 quotient bits and
// 5 head bits) and the result queue before it can be popped.
// Reset clears the queues and pipeline valid bits and loads the geometry
// registers with LBA mode, 63 sectors per track and 16 heads.
// When pop is held low the pipeline halts as a whole once the result queue
// fills; the command queue then fills and full rises.
// ----------------------------------------------------------------------------
module ata_taskfile_address_builder_unit #(
    parameter int unsigned CMD_DEPTH    = 2,
    parameter int unsigned RESULT_DEPTH = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [atatf_pkg::REG_IDX_W-1:0]    wr_index,
    input  logic [atatf_pkg::CFG_DATA_W-1:0]   wr_data,
    input  logic                               push,
    output logic                               full,
    input  logic [atatf_pkg::OFFSET_W-1:0]     sector_offset,
    input  logic [atatf_pkg::BYTE_W-1:0]       transfer_sectors,
    input  logic                               drive_select,
    input  logic                               drive_not_ready,
    output logic                               empty,
    input  logic                               pop,
    output logic                               not_ready_error,
    output logic [atatf_pkg::BYTE_W-1:0]       count_byte,
    output logic [atatf_pkg::BYTE_W-1:0]       sector_or_lba_low,
    output logic [atatf_pkg::BYTE_W-1:0]       cyl_low_or_lba_mid,
    output logic [atatf_pkg::BYTE_W-1:0]       cyl_high_or_lba_high,
    output logic [atatf_pkg::BYTE_W-1:0]       drive_head_byte,
    output logic                               cylinder_overflow
);

    localparam int unsigned ITEM_W   = $bits(atatf_pkg::item_t);
    localparam int unsigned RESULT_W = $bits(atatf_pkg::result_t);

    atatf_pkg::item_t    front_item;
    logic [ITEM_W-1:0]   cmd_rdata;
    logic                cmd_empty;
    logic                cmd_pop;
    atatf_pkg::result_t  back_result;
    logic                back_valid;
    logic                res_full;
    logic [RESULT_W-1:0] res_rdata;
    atatf_pkg::result_t  res_out;

    atatf_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .wr_en            (wr_en),
        .wr_index         (wr_index),
        .wr_data          (wr_data),
        .sector_offset    (sector_offset),
        .transfer_sectors (transfer_sectors),
        .drive_select     (drive_select),
        .drive_not_ready  (drive_not_ready),
        .item             (front_item)
    );

    atatf_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_rdata),
        .empty (cmd_empty)
    );

    atatf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (atatf_pkg::item_t'(cmd_rdata)),
        .item_valid   (!cmd_empty),
        .item_pop     (cmd_pop),
        .result       (back_result),
        .result_valid (back_valid),
        .result_full  (res_full)
    );

    atatf_queue #(
        .WIDTH (RESULT_W),
        .DEPTH (RESULT_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_valid),
        .wdata (back_result),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign res_out              = atatf_pkg::result_t'(res_rdata);
    assign not_ready_error      = res_out.not_ready_error;
    assign count_byte           = res_out.count_byte;
    assign sector_or_lba_low    = res_out.sector_or_lba_low;
    assign cyl_low_or_lba_mid   = res_out.cyl_low_or_lba_mid;
    assign cyl_high_or_lba_high = res_out.cyl_high_or_lba_high;
    assign drive_head_byte      = res_out.drive_head_byte;
    assign cylinder_overflow    = res_out.cylinder_overflow;

endmodule

// ===== design/atatf_checker.sv =====
// ----------------------------------------------------------------------------
// atatf_checker
// Port-level checks on the result stream of the address builder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atatf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       full,
    input logic       empty,
    input logic       pop,
    input logic       not_ready_error,
    input logic [7:0] count_byte,
    input logic [7:0] sector_or_lba_low,
    input logic [7:0] cyl_low_or_lba_mid,
    input logic [7:0] cyl_high_or_lba_high,
    input logic [7:0] drive_head_byte,
    input logic       cylinder_overflow
);

    // An error beat carries nothing but the error flag.
    `ATATF_ASSERT(a_error_clean, !empty && not_ready_error |-> count_byte == 8'h00 && sector_or_lba_low == 8'h00 && cyl_low_or_lba_mid == 8'h00 && cyl_high_or_lba_high == 8'h00 && drive_head_byte == 8'h00 && !cylinder_overflow, "error beat has nonzero fields")

    // An overflowing cylinder saturates and only occurs in CHS mode.
    `ATATF_ASSERT(a_ovf_saturate, !empty && cylinder_overflow |-> cyl_low_or_lba_mid == 8'hFF && cyl_high_or_lba_high == 8'hFF && !drive_head_byte[6] && !not_ready_error, "overflow beat not saturated")

    // Every good beat has the two fixed bits of the drive/head byte set.
    `ATATF_ASSERT(a_dh_fixed, !empty && !not_ready_error |-> drive_head_byte[7] && drive_head_byte[5], "drive/head fixed bits missing")

    `ATATF_ASSERT(a_result_held, !empty && !pop |=> !empty, "waiting result vanished")

    `ATATF_ASSERT_ALWAYS(a_reset_state, !rst_n |-> empty && !full, "queues not clear in reset")

endmodule

bind ata_taskfile_address_builder_unit atatf_checker u_atatf_checker (.*);
